// ===== rtl/i2c_tra_pkg.sv =====
// ----------------------------------------------------------------------------
// i2c target register access package
// shared types, codes and widths for the register-pointer layer
// ----------------------------------------------------------------------------
package i2c_tra_pkg;

    localparam int ADDR_W  = 7;
    localparam int CFG_W   = 7;
    localparam int CFGIX_W = 2;
    localparam int REQ_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int REG_W   = 16;
    localparam int CNT_W   = 2;

    // configuration register indexes
    localparam logic [CFGIX_W-1:0] CFG_TARGET_ADDRESS = 2'd0;
    localparam logic [CFGIX_W-1:0] CFG_POINTER_BYTES  = 2'd1;
    localparam logic [CFGIX_W-1:0] CFG_WRITE_ENABLE   = 2'd2;
    localparam logic [CFGIX_W-1:0] CFG_READ_ENABLE    = 2'd3;

    // pointer_bytes code that selects a two-byte pointer
    localparam logic [1:0] PTR_TWO_BYTES = 2'd2;

    // saturating byte counter limit
    localparam logic [CNT_W-1:0] CNT_MAX = 2'd3;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE_MATCH = 3'd0,
        REQ_BYTE_RX     = 3'd1,
        REQ_READ_MATCH  = 3'd2,
        REQ_BYTE_TX     = 3'd3,
        REQ_NAK         = 3'd4,
        REQ_STOP        = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WRITE = 2'd1,
        PH_READ  = 2'd2
    } t_phase;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 2'd1;
    endfunction

endpackage

// ===== rtl/i2c_target_register_access.sv =====
// ----------------------------------------------------------------------------
// i2c target register access
// register-pointer layer of an i2c target, one bus event per word
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  -------------------------------
//  in        input      i_in_valid / o_in_stall    req_type, data_byte, read_value
//  out       output     o_out_valid / i_out_stall  tx, write, pointer, flags
//  cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
//  one word per cycle sustained while the output is not stalled; a word is taken
//  into the input register when accepted and its result is then loaded into the
//  result register, from which it is offered on the out channel
//  reset (synchronous, active low) clears the phase, pointer, data value, byte
//  counters and configuration, pointer bytes apart (set to 1); no clearing pass
//  an out stall holds the result register; o_in_stall rises only when both
//  the input register and the result register hold words that cannot move
//
module i2c_target_register_access (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [i2c_tra_pkg::CFGIX_W-1:0]   i_cfg_index,
    input  logic [i2c_tra_pkg::CFG_W-1:0]     i_cfg_data,

    // bus event words
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [i2c_tra_pkg::REQ_W-1:0]     i_req_type,
    input  logic [i2c_tra_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic [i2c_tra_pkg::REG_W-1:0]     i_read_value,

    // result words
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_tx_valid,
    output logic [i2c_tra_pkg::BYTE_W-1:0]    o_tx_byte,
    output logic                              o_write_strobe,
    output logic [i2c_tra_pkg::REG_W-1:0]     o_write_address,
    output logic [i2c_tra_pkg::REG_W-1:0]     o_write_data,
    output logic [i2c_tra_pkg::REG_W-1:0]     o_pointer,
    output logic                              o_overflow,
    output logic                              o_underflow
);

    // configuration registers
    logic [i2c_tra_pkg::ADDR_W-1:0]  r_target_address;
    logic [1:0]                      r_pointer_bytes;
    logic                            r_write_enable;
    logic                            r_read_enable;

    // input register
    logic                            r_in_valid;
    logic [i2c_tra_pkg::REQ_W-1:0]   r_req_type;
    logic [i2c_tra_pkg::BYTE_W-1:0]  r_data_byte;
    logic [i2c_tra_pkg::REG_W-1:0]   r_read_value;

    // transaction state
    i2c_tra_pkg::t_phase             r_phase, n_phase;
    logic [i2c_tra_pkg::REG_W-1:0]   r_reg_pointer, n_reg_pointer;
    logic [i2c_tra_pkg::REG_W-1:0]   r_data_value, n_data_value;
    logic [i2c_tra_pkg::CNT_W-1:0]   r_bytes_received, n_bytes_received;
    logic [i2c_tra_pkg::CNT_W-1:0]   r_data_bytes_seen, n_data_bytes_seen;
    logic [i2c_tra_pkg::CNT_W-1:0]   r_tx_count, n_tx_count;

    // result register
    logic                            r_out_valid;
    logic                            r_tx_valid, n_tx_valid;
    logic [i2c_tra_pkg::BYTE_W-1:0]  r_tx_byte, n_tx_byte;
    logic                            r_write_strobe, n_write_strobe;
    logic [i2c_tra_pkg::REG_W-1:0]   r_write_address, n_write_address;
    logic [i2c_tra_pkg::REG_W-1:0]   r_write_data, n_write_data;
    logic [i2c_tra_pkg::REG_W-1:0]   r_pointer;
    logic                            r_overflow, n_overflow;
    logic                            r_underflow, n_underflow;

    logic out_blocked;
    logic advance;
    logic in_take;
    logic two_ptr;

    // result register can only be refilled when empty or being drained
    assign out_blocked = r_out_valid && i_out_stall;
    assign advance     = r_in_valid && !out_blocked;
    assign o_in_stall  = r_in_valid && out_blocked;
    assign in_take     = i_in_valid && !o_in_stall;
    assign two_ptr     = (r_pointer_bytes == i2c_tra_pkg::PTR_TWO_BYTES);

    // event decode and state update
    always_comb begin
        n_phase           = r_phase;
        n_reg_pointer     = r_reg_pointer;
        n_data_value      = r_data_value;
        n_bytes_received  = r_bytes_received;
        n_data_bytes_seen = r_data_bytes_seen;
        n_tx_count        = r_tx_count;
        n_tx_valid        = 1'b0;
        n_tx_byte         = '0;
        n_write_strobe    = 1'b0;
        n_write_address   = '0;
        n_write_data      = '0;
        n_overflow        = 1'b0;
        n_underflow       = 1'b0;

        // unconfigured address ignores every event
        if (r_target_address != '0) begin
            unique case (r_req_type)
                i2c_tra_pkg::REQ_WRITE_MATCH: begin
                    if (r_phase == i2c_tra_pkg::PH_IDLE && r_write_enable) begin
                        n_phase           = i2c_tra_pkg::PH_WRITE;
                        n_bytes_received  = '0;
                        n_data_bytes_seen = '0;
                        n_data_value      = '0;
                    end
                end
                i2c_tra_pkg::REQ_BYTE_RX: begin
                    if (r_phase == i2c_tra_pkg::PH_WRITE) begin
                        if (r_bytes_received == '0 ||
                            (two_ptr && r_bytes_received == 2'd1)) begin
                            // pointer bytes, big-endian when two
                            if (two_ptr && r_bytes_received == '0) begin
                                n_reg_pointer = {r_data_byte, r_reg_pointer[7:0]};
                            end else if (two_ptr) begin
                                n_reg_pointer = {r_reg_pointer[15:8], r_data_byte};
                            end else begin
                                n_reg_pointer = {8'h00, r_data_byte};
                            end
                        end else begin
                            // data bytes, little-endian, extras flagged
                            if (r_data_bytes_seen == '0) begin
                                n_data_value = {8'h00, r_data_byte};
                            end else if (r_data_bytes_seen == 2'd1) begin
                                n_data_value = {r_data_byte, r_data_value[7:0]};
                            end else begin
                                n_overflow = 1'b1;
                            end
                            n_data_bytes_seen = i2c_tra_pkg::sat_inc(r_data_bytes_seen);
                        end
                        n_bytes_received = i2c_tra_pkg::sat_inc(r_bytes_received);
                    end
                end
                i2c_tra_pkg::REQ_READ_MATCH: begin
                    // repeated start from a write always turns into a read
                    if (r_phase == i2c_tra_pkg::PH_WRITE ||
                        (r_phase == i2c_tra_pkg::PH_IDLE && r_read_enable)) begin
                        n_phase      = i2c_tra_pkg::PH_READ;
                        n_data_value = r_read_value;
                        n_tx_valid   = 1'b1;
                        n_tx_byte    = r_read_value[7:0];
                        n_tx_count   = 2'd1;
                    end
                end
                i2c_tra_pkg::REQ_BYTE_TX: begin
                    if (r_phase == i2c_tra_pkg::PH_READ) begin
                        n_tx_valid = 1'b1;
                        if (r_tx_count == '0) begin
                            n_tx_byte = r_data_value[7:0];
                        end else if (r_tx_count == 2'd1) begin
                            n_tx_byte = r_data_value[15:8];
                        end else begin
                            n_underflow = 1'b1;
                        end
                        n_tx_count = i2c_tra_pkg::sat_inc(r_tx_count);
                    end
                end
                i2c_tra_pkg::REQ_NAK: begin
                    if (r_phase == i2c_tra_pkg::PH_READ) begin
                        n_phase = i2c_tra_pkg::PH_IDLE;
                    end
                end
                i2c_tra_pkg::REQ_STOP: begin
                    // pointer-only write commits nothing
                    if (r_phase == i2c_tra_pkg::PH_WRITE && r_data_bytes_seen != '0) begin
                        n_write_strobe  = 1'b1;
                        n_write_address = r_reg_pointer;
                        n_write_data    = r_data_value;
                    end
                    n_phase = i2c_tra_pkg::PH_IDLE;
                end
                default: begin
                end
            endcase
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_address  <= '0;
            r_pointer_bytes   <= 2'd1;
            r_write_enable    <= 1'b0;
            r_read_enable     <= 1'b0;
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_phase           <= i2c_tra_pkg::PH_IDLE;
            r_reg_pointer     <= '0;
            r_data_value      <= '0;
            r_bytes_received  <= '0;
            r_data_bytes_seen <= '0;
            r_tx_count        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    i2c_tra_pkg::CFG_TARGET_ADDRESS: r_target_address <= i_cfg_data;
                    i2c_tra_pkg::CFG_POINTER_BYTES:  r_pointer_bytes  <= i_cfg_data[1:0];
                    i2c_tra_pkg::CFG_WRITE_ENABLE:   r_write_enable   <= i_cfg_data[0];
                    i2c_tra_pkg::CFG_READ_ENABLE:    r_read_enable    <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end

            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (advance) begin
                r_phase           <= n_phase;
                r_reg_pointer     <= n_reg_pointer;
                r_data_value      <= n_data_value;
                r_bytes_received  <= n_bytes_received;
                r_data_bytes_seen <= n_data_bytes_seen;
                r_tx_count        <= n_tx_count;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req_type   <= i_req_type;
            r_data_byte  <= i_data_byte;
            r_read_value <= i_read_value;
        end
        if (advance) begin
            r_tx_valid      <= n_tx_valid;
            r_tx_byte       <= n_tx_byte;
            r_write_strobe  <= n_write_strobe;
            r_write_address <= n_write_address;
            r_write_data    <= n_write_data;
            r_overflow      <= n_overflow;
            r_underflow     <= n_underflow;
            r_pointer       <= n_reg_pointer;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_tx_valid      = r_tx_valid;
    assign o_tx_byte       = r_tx_byte;
    assign o_write_strobe  = r_write_strobe;
    assign o_write_address = r_write_address;
    assign o_write_data    = r_write_data;
    assign o_pointer       = r_pointer;
    assign o_overflow      = r_overflow;
    assign o_underflow     = r_underflow;

endmodule
